// File: hdl/ut8_pkg.sv
`timescale 1ns / 1ps

package ut8_pkg;

    // One tick word as it travels from the front stage to the back end
    typedef struct packed {
        logic       rx_line;
        logic       send_request;
        logic [7:0] send_byte;
        logic       receive_request;
    } word_t;

    typedef logic [3:0] phase_t;
    typedef logic [8:0] tick_t;

    // Register indexes
    localparam logic CFG_BAUD_SELECT     = 1'b0;
    localparam logic CFG_RECEIVE_TIMEOUT = 1'b1;

    localparam logic [1:0]  BAUD_OFF      = 2'd3;
    localparam logic [23:0] TIMEOUT_RESET = 24'd200000;

    // Phase codes
    localparam phase_t PH_IDLE   = 4'd0;
    localparam phase_t TX_START  = 4'd1;
    localparam phase_t TX_DATA0  = 4'd2;
    localparam phase_t TX_DATA7  = 4'd9;
    localparam phase_t TX_STOP   = 4'd10;
    localparam phase_t RX_WAIT   = 4'd1;
    localparam phase_t RX_START  = 4'd2;
    localparam phase_t RX_HOLD   = 4'd10;

    // Delay from start edge to the first sample
    function automatic tick_t start_delay(input logic [1:0] sel);
        tick_t d;
        unique case (sel)
            2'd1:    d = 9'd200;
            2'd2:    d = 9'd37;
            default: d = 9'd300;
        endcase
        return d;
    endfunction

    // One bit period, shared by sampling and serializing
    function automatic tick_t bit_period(input logic [1:0] sel);
        tick_t d;
        unique case (sel)
            2'd1:    d = 9'd100;
            2'd2:    d = 9'd23;
            default: d = 9'd200;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/uart_8n1_tick_transceiver_core.sv
`timescale 1ns / 1ps

// 8N1 UART transceiver stepped by a one-microsecond tick word.
// Input channel (in_valid/in_ready): one word per tick, carrying the sampled
// receive line, a send request with its byte and a receive request.
// Output channel (out_valid/out_ready): exactly one word per input word, giving
// the transmit line level, both busy flags and, when rx_valid is set, the
// received byte and the timeout flag.
// Configuration: write baud_select (index 0) or receive_timeout (index 1) with
// cfg_we; no handshake, and only while no tick word is in flight.
// Path: the result word is registered; an accepted word passes the front holding
// stage, the two-word queue and the back end's output register, in that order.
// Throughput: one word per cycle while out_ready stays high; the back end updates
// both the transmit and the receive state machines together on each tick.
// Reset: both state machines go idle, baud_select returns to 4800 and
// receive_timeout to 200000 ticks; no words are held.
// Stall: while out_ready is low the result word holds, the back end stops
// popping, the queue fills and then in_ready drops; nothing is lost.
module uart_8n1_tick_transceiver_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        rx_line,
    input  logic        send_request,
    input  logic [7:0]  send_byte,
    input  logic        receive_request,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tx_line,
    output logic        tx_busy,
    output logic        rx_busy,
    output logic        rx_valid,
    output logic [7:0]  rx_byte,
    output logic        rx_timed_out
);

    ut8_pkg::word_t in_word;
    ut8_pkg::word_t push_word;
    ut8_pkg::word_t pop_word;
    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           pop;

    // Gather the tick fields into one word
    assign in_word.rx_line         = rx_line;
    assign in_word.send_request    = send_request;
    assign in_word.send_byte       = send_byte;
    assign in_word.receive_request = receive_request;

    // Front: hold the accepted word until the queue takes it
    ut8_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .push      (push),
        .push_word (push_word),
        .q_ready   (q_ready)
    );

    // Queue: lets the front keep accepting while the output stalls briefly
    ut8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_word  (pop_word)
    );

    // Back: transmit and receive state machines plus the result register
    ut8_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .pop_word     (pop_word),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tx_line      (tx_line),
        .tx_busy      (tx_busy),
        .rx_busy      (rx_busy),
        .rx_valid     (rx_valid),
        .rx_byte      (rx_byte),
        .rx_timed_out (rx_timed_out)
    );

endmodule

// File: hdl/ut8_front.sv
`timescale 1ns / 1ps

module ut8_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ut8_pkg::word_t in_word,
    output logic          push,
    output ut8_pkg::word_t push_word,
    input  logic          q_ready
);

    logic           hold_valid_reg;
    logic           hold_valid_next;
    ut8_pkg::word_t hold_word_reg;
    logic           accept;

    // Take a new word whenever the holding slot is empty or drains this cycle
    assign push     = hold_valid_reg && q_ready;
    assign in_ready = !hold_valid_reg || q_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    // Pass the held word to the queue as it is
    always_comb
    begin
        push_word = hold_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_word_reg <= in_word;
        end
    end

endmodule

// File: hdl/ut8_queue.sv
`timescale 1ns / 1ps

module ut8_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ut8_pkg::word_t push_word,
    output logic           q_ready,
    input  logic           pop,
    output logic           q_valid,
    output ut8_pkg::word_t pop_word
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ut8_pkg::word_t        mem_reg [DEPTH];
    logic [PW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign q_ready  = count_reg != CW'(DEPTH);
    assign q_valid  = count_reg != '0;
    assign pop_word = mem_reg[rd_ptr_reg];
    assign do_push  = push && q_ready;
    assign do_pop   = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: hdl/ut8_back.sv
`timescale 1ns / 1ps

module ut8_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [23:0]    cfg_data,
    input  logic           q_valid,
    input  ut8_pkg::word_t pop_word,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           tx_line,
    output logic           tx_busy,
    output logic           rx_busy,
    output logic           rx_valid,
    output logic [7:0]     rx_byte,
    output logic           rx_timed_out
);

    logic [1:0]        baud_reg;
    logic [23:0]       timeout_reg;

    ut8_pkg::phase_t   tx_phase_reg, tx_phase_next;
    ut8_pkg::tick_t    tx_cnt_reg, tx_cnt_next;
    logic [7:0]        tx_shift_reg, tx_shift_next;
    ut8_pkg::phase_t   rx_phase_reg, rx_phase_next;
    ut8_pkg::tick_t    rx_cnt_reg, rx_cnt_next;
    logic [7:0]        rx_shift_reg, rx_shift_next;
    logic [23:0]       rx_wait_reg, rx_wait_next;

    logic              out_valid_reg;
    logic              tx_line_reg, tx_busy_reg, rx_busy_reg;
    logic              rx_valid_reg, rx_timed_out_reg;
    logic [7:0]        rx_byte_reg;

    logic              txl, vld, tmo;
    logic [7:0]        rbyte;
    logic              enabled;
    logic [1:0]        sel;
    ut8_pkg::tick_t    sd, bd, rd;

    // Advance one tick whenever the output slot is free or being taken
    assign pop     = q_valid && (!out_valid_reg || out_ready);
    assign enabled = baud_reg != ut8_pkg::BAUD_OFF;
    assign sel     = enabled ? baud_reg : 2'd0;
    assign sd      = ut8_pkg::start_delay(sel);
    assign bd      = ut8_pkg::bit_period(sel);

    always_comb
    begin
        tx_phase_next = (tx_phase_reg > ut8_pkg::TX_STOP) ? ut8_pkg::PH_IDLE : tx_phase_reg;
        tx_cnt_next   = tx_cnt_reg;
        tx_shift_next = tx_shift_reg;
        rx_phase_next = (rx_phase_reg > ut8_pkg::RX_HOLD) ? ut8_pkg::PH_IDLE : rx_phase_reg;
        rx_cnt_next   = rx_cnt_reg;
        rx_shift_next = rx_shift_reg;
        rx_wait_next  = rx_wait_reg;
        vld           = 1'b0;
        tmo           = 1'b0;
        rbyte         = 8'd0;
        rd            = bd;

        // transmitter
        if (tx_phase_next != ut8_pkg::PH_IDLE)
        begin
            if (!enabled)
            begin
                tx_phase_next = ut8_pkg::PH_IDLE;
                tx_cnt_next   = '0;
            end
            else
            begin
                tx_cnt_next = tx_cnt_next + 1'b1;
                if (tx_cnt_next >= bd)
                begin
                    tx_cnt_next   = '0;
                    tx_phase_next = (tx_phase_next == ut8_pkg::TX_STOP) ?
                                    ut8_pkg::PH_IDLE : tx_phase_next + 1'b1;
                end
            end
        end
        if (tx_phase_next == ut8_pkg::PH_IDLE && pop_word.send_request && enabled)
        begin
            tx_phase_next = ut8_pkg::TX_START;
            tx_cnt_next   = '0;
            tx_shift_next = pop_word.send_byte;
        end
        if (tx_phase_next == ut8_pkg::TX_START)
        begin
            txl = 1'b0;
        end
        else if (tx_phase_next >= ut8_pkg::TX_DATA0 && tx_phase_next <= ut8_pkg::TX_DATA7)
        begin
            txl = tx_shift_next[3'(tx_phase_next - ut8_pkg::TX_DATA0)];
        end
        else
        begin
            txl = 1'b1;
        end

        // receiver: request or disable first
        if (rx_phase_next == ut8_pkg::PH_IDLE)
        begin
            if (pop_word.receive_request)
            begin
                if (!enabled)
                begin
                    vld = 1'b1;
                    tmo = 1'b1;
                end
                else
                begin
                    rx_phase_next = ut8_pkg::RX_WAIT;
                    rx_wait_next  = '0;
                    rx_shift_next = '0;
                    rx_cnt_next   = '0;
                end
            end
        end
        else if (!enabled)
        begin
            rx_phase_next = ut8_pkg::PH_IDLE;
            vld           = 1'b1;
            tmo           = 1'b1;
        end

        if (rx_phase_next == ut8_pkg::RX_WAIT)
        begin
            if (!pop_word.rx_line)
            begin
                rx_phase_next = ut8_pkg::RX_START;
                rx_cnt_next   = '0;
            end
            else if (rx_wait_next >= timeout_reg)
            begin
                rx_phase_next = ut8_pkg::PH_IDLE;
                vld           = 1'b1;
                tmo           = 1'b1;
            end
            else
            begin
                rx_wait_next = rx_wait_next + 1'b1;
            end
        end
        else if (rx_phase_next >= ut8_pkg::RX_START)
        begin
            rd          = (rx_phase_next == ut8_pkg::RX_START) ? sd : bd;
            rx_cnt_next = rx_cnt_next + 1'b1;
            if (rx_cnt_next >= rd)
            begin
                rx_cnt_next = '0;
                if (rx_phase_next == ut8_pkg::RX_HOLD)
                begin
                    rx_phase_next = ut8_pkg::PH_IDLE;
                    vld           = 1'b1;
                    rbyte         = rx_shift_next;
                end
                else
                begin
                    rx_shift_next[3'(rx_phase_next - ut8_pkg::RX_START)] =
                        rx_shift_next[3'(rx_phase_next - ut8_pkg::RX_START)] |
                        pop_word.rx_line;
                    rx_phase_next = rx_phase_next + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baud_reg     <= 2'd0;
            timeout_reg  <= ut8_pkg::TIMEOUT_RESET;
            tx_phase_reg <= ut8_pkg::PH_IDLE;
            tx_cnt_reg   <= '0;
            tx_shift_reg <= '0;
            rx_phase_reg <= ut8_pkg::PH_IDLE;
            rx_cnt_reg   <= '0;
            rx_shift_reg <= '0;
            rx_wait_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ut8_pkg::CFG_BAUD_SELECT:     baud_reg    <= cfg_data[1:0];
                    ut8_pkg::CFG_RECEIVE_TIMEOUT: timeout_reg <= cfg_data;
                    default:                      ;
                endcase
            end
            if (pop)
            begin
                tx_phase_reg <= tx_phase_next;
                tx_cnt_reg   <= tx_cnt_next;
                tx_shift_reg <= tx_shift_next;
                rx_phase_reg <= rx_phase_next;
                rx_cnt_reg   <= rx_cnt_next;
                rx_shift_reg <= rx_shift_next;
                rx_wait_reg  <= rx_wait_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tx_line_reg      <= txl;
            tx_busy_reg      <= tx_phase_next != ut8_pkg::PH_IDLE;
            rx_busy_reg      <= rx_phase_next != ut8_pkg::PH_IDLE;
            rx_valid_reg     <= vld;
            rx_byte_reg      <= rbyte;
            rx_timed_out_reg <= tmo;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tx_line      = tx_line_reg;
    assign tx_busy      = tx_busy_reg;
    assign rx_busy      = rx_busy_reg;
    assign rx_valid     = rx_valid_reg;
    assign rx_byte      = rx_byte_reg;
    assign rx_timed_out = rx_timed_out_reg;

endmodule

// File: hdl/ut8_checker.sv
`timescale 1ns / 1ps

module ut8_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       tx_line,
    input logic       tx_busy,
    input logic       rx_busy,
    input logic       rx_valid,
    input logic [7:0] rx_byte,
    input logic       rx_timed_out
);

    // Hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rx_byte) && $stable(tx_line))
        else $error("stalled result changed");

    // Report fields stay clear unless a receive finished
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rx_valid |-> rx_byte == 8'd0 && !rx_timed_out)
        else $error("receive fields set without rx_valid");

    // A timeout carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rx_timed_out |-> rx_byte == 8'd0)
        else $error("timeout with nonzero byte");

    // A finished receive leaves the receiver idle, an idle transmitter drives high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rx_valid |-> !rx_busy)
        else $error("receiver busy after finishing");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_busy |-> tx_line)
        else $error("idle transmitter drives low");

endmodule

bind uart_8n1_tick_transceiver_core ut8_checker u_ut8_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_line      (tx_line),
    .tx_busy      (tx_busy),
    .rx_busy      (rx_busy),
    .rx_valid     (rx_valid),
    .rx_byte      (rx_byte),
    .rx_timed_out (rx_timed_out)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Run limits and pacing
    localparam int LIMIT_CYCLES  = 600000;
    localparam int PHASE_WORDS   = 230;
    localparam int RANDOM_PHASES = 8;
    localparam int SETTLE_CYCLES = 8;

    // Delay presets per baud selection: 4800, 9600, 38400
    localparam ut8_pkg::tick_t START_TICKS [3] = '{9'd300, 9'd200, 9'd37};
    localparam ut8_pkg::tick_t BIT_TICKS   [3] = '{9'd200, 9'd100, 9'd23};

    // Baud selection used by each random phase; the off setting appears once
    localparam logic [1:0] PHASE_BAUD [RANDOM_PHASES] =
        '{2'd2, 2'd2, 2'd1, 2'd2, 2'd0, 2'd2, ut8_pkg::BAUD_OFF, 2'd2};

    // One result word as the block reports it for a tick
    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       rx_busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_timed_out;
    } line_status_t;

    // One row of the directed script: a register write or a tick word
    typedef struct packed {
        logic           is_cfg;
        logic           cfg_idx;
        logic [23:0]    cfg_val;
        ut8_pkg::word_t tick;
        logic           has_exp;
        line_status_t   exp;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        rx_line;
    logic        send_request;
    logic [7:0]  send_byte;
    logic        receive_request;
    logic        out_valid;
    logic        out_ready;
    logic        tx_line;
    logic        tx_busy;
    logic        rx_busy;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        rx_timed_out;

    // Predictor copy of the transceiver state and its registers
    ut8_pkg::phase_t tx_ph;
    ut8_pkg::tick_t  tx_ticks;
    logic [7:0]      tx_bits;
    ut8_pkg::phase_t rx_ph;
    ut8_pkg::tick_t  rx_ticks;
    logic [7:0]      rx_bits;
    logic [23:0]     rx_wait;
    logic [1:0]      baud_sel;
    logic [23:0]     rx_timeout;

    line_status_t status_due[$];   // predicted status words, oldest first
    line_status_t want;
    logic         rx_wave[$];      // planned far-end levels for rx_line
    script_row_t  script[$];

    int send_idle_pct;
    int stall_pct;
    int errors = 0;
    int cycles = 0;

    uart_8n1_tick_transceiver_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_line         (rx_line),
        .send_request    (send_request),
        .send_byte       (send_byte),
        .receive_request (receive_request),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tx_line         (tx_line),
        .tx_busy         (tx_busy),
        .rx_busy         (rx_busy),
        .rx_valid        (rx_valid),
        .rx_byte         (rx_byte),
        .rx_timed_out    (rx_timed_out)
    );

    always #2 clk = ~clk;

    // Advance the predicted transceiver by one tick and return its status word.
    // Transmitter first, then receiver, exactly as the block orders them.
    function automatic line_status_t advance_uart(input ut8_pkg::word_t w);
        line_status_t   r;
        logic           on;
        logic [1:0]     sel;
        ut8_pkg::tick_t bit_d;
        ut8_pkg::tick_t d;
        r = '0;
        on = (baud_sel != ut8_pkg::BAUD_OFF);
        sel = on ? baud_sel : 2'd0;
        bit_d = BIT_TICKS[sel];

        // Transmitter: count out the current bit, drop the frame when disabled
        if (tx_ph > ut8_pkg::TX_STOP)
            tx_ph = ut8_pkg::PH_IDLE;
        if (tx_ph != ut8_pkg::PH_IDLE)
        begin
            if (!on)
            begin
                tx_ph = ut8_pkg::PH_IDLE;
                tx_ticks = '0;
            end
            else
            begin
                tx_ticks = tx_ticks + 9'd1;
                if (tx_ticks >= bit_d)
                begin
                    tx_ticks = '0;
                    tx_ph = (tx_ph == ut8_pkg::TX_STOP) ? ut8_pkg::PH_IDLE : tx_ph + 4'd1;
                end
            end
        end
        // A frame may start on the very tick the previous one ends
        if (tx_ph == ut8_pkg::PH_IDLE && w.send_request && on)
        begin
            tx_ph = ut8_pkg::TX_START;
            tx_ticks = '0;
            tx_bits = w.send_byte;
        end
        if (tx_ph == ut8_pkg::TX_START)
            r.tx_line = 1'b0;
        else if (tx_ph >= ut8_pkg::TX_DATA0 && tx_ph <= ut8_pkg::TX_DATA7)
            r.tx_line = tx_bits[3'(tx_ph - ut8_pkg::TX_DATA0)];
        else
            r.tx_line = 1'b1;

        // Receiver: a request counts only if idle at the start of the tick
        if (rx_ph > ut8_pkg::RX_HOLD)
            rx_ph = ut8_pkg::PH_IDLE;
        if (rx_ph == ut8_pkg::PH_IDLE)
        begin
            if (w.receive_request)
            begin
                if (!on)
                begin
                    r.rx_valid = 1'b1;
                    r.rx_timed_out = 1'b1;
                end
                else
                begin
                    rx_ph = ut8_pkg::RX_WAIT;
                    rx_wait = '0;
                    rx_bits = '0;
                    rx_ticks = '0;
                end
            end
        end
        else if (!on)
        begin
            rx_ph = ut8_pkg::PH_IDLE;
            r.rx_valid = 1'b1;
            r.rx_timed_out = 1'b1;
        end

        if (rx_ph == ut8_pkg::RX_WAIT)
        begin
            if (!w.rx_line)
            begin
                rx_ph = ut8_pkg::RX_START;
                rx_ticks = '0;
            end
            else if (rx_wait >= rx_timeout)
            begin
                rx_ph = ut8_pkg::PH_IDLE;
                r.rx_valid = 1'b1;
                r.rx_timed_out = 1'b1;
            end
            else
                rx_wait = rx_wait + 24'd1;
        end
        else if (rx_ph >= ut8_pkg::RX_START)
        begin
            d = (rx_ph == ut8_pkg::RX_START) ? START_TICKS[sel] : bit_d;
            rx_ticks = rx_ticks + 9'd1;
            if (rx_ticks >= d)
            begin
                rx_ticks = '0;
                if (rx_ph == ut8_pkg::RX_HOLD)
                begin
                    rx_ph = ut8_pkg::PH_IDLE;
                    r.rx_valid = 1'b1;
                    r.rx_byte = rx_bits;
                end
                else
                begin
                    rx_bits[3'(rx_ph - ut8_pkg::RX_START)] =
                        rx_bits[3'(rx_ph - ut8_pkg::RX_START)] | w.rx_line;
                    rx_ph = rx_ph + 4'd1;
                end
            end
        end

        r.tx_busy = (tx_ph != ut8_pkg::PH_IDLE);
        r.rx_busy = (rx_ph != ut8_pkg::PH_IDLE);
        return r;
    endfunction

    function automatic ut8_pkg::word_t mk_word(input logic line, input logic sreq,
                                               input logic [7:0] sbyte, input logic rreq);
        ut8_pkg::word_t w;
        w.rx_line = line;
        w.send_request = sreq;
        w.send_byte = sbyte;
        w.receive_request = rreq;
        return w;
    endfunction

    function automatic line_status_t mk_status(input logic txl, input logic txb,
                                               input logic rxb, input logic rv,
                                               input logic tmo);
        line_status_t s;
        s = '0;
        s.tx_line = txl;
        s.tx_busy = txb;
        s.rx_busy = rxb;
        s.rx_valid = rv;
        s.rx_timed_out = tmo;
        return s;
    endfunction

    function automatic script_row_t row_tick(input ut8_pkg::word_t w, input logic has_exp,
                                             input line_status_t exp);
        script_row_t r;
        r = '0;
        r.tick = w;
        r.has_exp = has_exp;
        r.exp = exp;
        return r;
    endfunction

    function automatic script_row_t row_cfg(input logic idx, input logic [23:0] val);
        script_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    // Stop presenting words and wait until every predicted status has been
    // checked, then let the pipeline settle for as long as the caller asks.
    task automatic drain(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // Write one register with the pipeline empty; the predictor follows suit.
    task automatic write_reg(input logic idx, input logic [23:0] val);
        drain(SETTLE_CYCLES);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == ut8_pkg::CFG_BAUD_SELECT)
            baud_sel = val[1:0];
        else
            rx_timeout = val;
    endtask

    // Present one tick word, hold it until taken, then log its expected status.
    // A typed status, where given, replaces the predicted one.
    task automatic push_tick(input ut8_pkg::word_t w, input logic typed,
                             input line_status_t typed_exp);
        line_status_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_line <= w.rx_line;
        send_request <= w.send_request;
        send_byte <= w.send_byte;
        receive_request <= w.receive_request;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = advance_uart(w);
        status_due.push_back(typed ? typed_exp : predicted);
    endtask

    // Plan the far end of the receive line: mostly clean 8N1 frames at the
    // current bit period, with idle stretches, short noise, slight period skew
    // and the odd bad stop bit mixed in.
    task automatic plan_rx_wave();
        int         pick;
        int         per;
        logic [7:0] b;
        pick = $urandom_range(99);
        per = (baud_sel == ut8_pkg::BAUD_OFF) ? int'(BIT_TICKS[2]) :
                                                int'(BIT_TICKS[baud_sel]);
        if (pick < 15)
        begin
            repeat ($urandom_range(1, 12)) rx_wave.push_back(1'($urandom_range(1)));
        end
        else if (pick < 30)
        begin
            repeat ($urandom_range(1, 40)) rx_wave.push_back(1'b1);
        end
        else
        begin
            b = 8'($urandom());
            if ($urandom_range(3) == 0)
                per = per + int'($urandom_range(2)) - 1;
            repeat (per) rx_wave.push_back(1'b0);
            for (int i = 0; i < 8; i++)
                repeat (per) rx_wave.push_back(b[i]);
            repeat (per) rx_wave.push_back($urandom_range(9) != 0);
            repeat ($urandom_range(10)) rx_wave.push_back(1'b1);
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
        end
    endtask

    // Receiver side: stall at random per the current pressure setting
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Compare every status word taken against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (status_due.size() == 0)
            begin
                errors++;
                $display("%0t: status word expected none, actual %h", $time,
                         {tx_line, tx_busy, rx_busy, rx_valid, rx_byte, rx_timed_out});
            end
            else
            begin
                want = status_due.pop_front();
                check_field("tx_line", want.tx_line, tx_line);
                check_field("tx_busy", want.tx_busy, tx_busy);
                check_field("rx_busy", want.rx_busy, rx_busy);
                check_field("rx_valid", want.rx_valid, rx_valid);
                check_field("rx_byte", want.rx_byte, rx_byte);
                check_field("rx_timed_out", want.rx_timed_out, rx_timed_out);
            end
        end
    end

    // Watchdog: a hung handshake ends the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        ut8_pkg::word_t w;
        line_status_t   none;
        logic [23:0]    tmo;

        // Drive every input to a known level before reset
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ut8_pkg::CFG_BAUD_SELECT;
        cfg_data = '0;
        in_valid = 1'b0;
        rx_line = 1'b1;
        send_request = 1'b0;
        send_byte = '0;
        receive_request = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;

        // Predictor starts from the reset state
        tx_ph = ut8_pkg::PH_IDLE;
        tx_ticks = '0;
        tx_bits = '0;
        rx_ph = ut8_pkg::PH_IDLE;
        rx_ticks = '0;
        rx_bits = '0;
        rx_wait = '0;
        baud_sel = 2'd0;
        rx_timeout = ut8_pkg::TIMEOUT_RESET;
        none = '0;

        // Directed script. Typed rows are the ones obvious by inspection.
        // Idle after reset
        script.push_back(row_tick(mk_word(1'b1, 1'b0, 8'h00, 1'b0), 1'b1,
                                  mk_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0)));
        // Frame start drives the start bit on the same tick
        script.push_back(row_tick(mk_word(1'b1, 1'b1, 8'hFF, 1'b0), 1'b1,
                                  mk_status(1'b0, 1'b1, 1'b0, 1'b0, 1'b0)));
        // Send while busy is dropped; receive sees the line already low
        script.push_back(row_tick(mk_word(1'b0, 1'b1, 8'h00, 1'b1), 1'b0, none));
        // Disable mid-frame and mid-receive
        script.push_back(row_cfg(ut8_pkg::CFG_BAUD_SELECT, {22'd0, ut8_pkg::BAUD_OFF}));
        script.push_back(row_tick(mk_word(1'b1, 1'b1, 8'h5A, 1'b1), 1'b1,
                                  mk_status(1'b1, 1'b0, 1'b0, 1'b1, 1'b1)));
        // Receive while disabled answers at once, send is refused
        script.push_back(row_tick(mk_word(1'b1, 1'b0, 8'h00, 1'b1), 1'b1,
                                  mk_status(1'b1, 1'b0, 1'b0, 1'b1, 1'b1)));
        script.push_back(row_tick(mk_word(1'b0, 1'b1, 8'hFF, 1'b0), 1'b1,
                                  mk_status(1'b1, 1'b0, 1'b0, 1'b0, 1'b0)));
        // Zero timeout with the line high gives up on the request tick
        script.push_back(row_cfg(ut8_pkg::CFG_BAUD_SELECT, 24'd2));
        script.push_back(row_cfg(ut8_pkg::CFG_RECEIVE_TIMEOUT, 24'd0));
        script.push_back(row_tick(mk_word(1'b1, 1'b0, 8'h00, 1'b1), 1'b1,
                                  mk_status(1'b1, 1'b0, 1'b0, 1'b1, 1'b1)));
        script.push_back(row_tick(mk_word(1'b1, 1'b1, 8'h00, 1'b1), 1'b1,
                                  mk_status(1'b0, 1'b1, 1'b0, 1'b1, 1'b1)));
        script.push_back(row_tick(mk_word(1'b0, 1'b0, 8'h00, 1'b1), 1'b0, none));
        // Largest timeout, then rate changes while both sides are busy
        script.push_back(row_cfg(ut8_pkg::CFG_RECEIVE_TIMEOUT, 24'hFFFFFF));
        script.push_back(row_cfg(ut8_pkg::CFG_BAUD_SELECT, 24'd1));
        script.push_back(row_tick(mk_word(1'b0, 1'b0, 8'h00, 1'b0), 1'b0, none));
        script.push_back(row_cfg(ut8_pkg::CFG_BAUD_SELECT, 24'd0));
        script.push_back(row_tick(mk_word(1'b1, 1'b1, 8'h81, 1'b1), 1'b0, none));
        script.push_back(row_tick(mk_word(1'b1, 1'b0, 8'h7E, 1'b0), 1'b0, none));
        script.push_back(row_cfg(ut8_pkg::CFG_BAUD_SELECT, 24'd2));
        script.push_back(row_cfg(ut8_pkg::CFG_RECEIVE_TIMEOUT, 24'd40));
        script.push_back(row_tick(mk_word(1'b1, 1'b0, 8'hC3, 1'b1), 1'b0, none));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_reg(script[i].cfg_idx, script[i].cfg_val);
            else
                push_tick(script[i].tick, script[i].has_exp, script[i].exp);
        end

        // Random phases: rotate through no pressure, idle sender, stalling
        // receiver and both; rewrite the registers between phases so rate and
        // timeout changes land on frames still in progress.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 63;
                end
                default:
                begin
                    send_idle_pct = 18;
                    stall_pct = 18;
                end
            endcase
            tmo = ($urandom_range(4) == 0) ? 24'($urandom()) : 24'($urandom_range(300));
            write_reg(ut8_pkg::CFG_BAUD_SELECT, {22'd0, PHASE_BAUD[ph]});
            write_reg(ut8_pkg::CFG_RECEIVE_TIMEOUT, tmo);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                // Hold off once until everything in flight has come back
                if (ph == 1 && k == PHASE_WORDS / 2)
                    drain(0);
                if (rx_wave.size() == 0)
                    plan_rx_wave();
                w.rx_line = rx_wave.pop_front();
                w.send_request = ($urandom_range(39) == 0);
                w.send_byte = 8'($urandom());
                w.receive_request = ($urandom_range(14) == 0);
                push_tick(w, 1'b0, none);
            end
        end

        // Drain, then give any stray word time to show up
        drain(4 * SETTLE_CYCLES);
        if (errors == 0 && status_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
